@@ rtl/core/lmlpc_pkg.sv @@
// Shared types, constants and helpers of the layer mode LED pattern controller.
package lmlpc_pkg;

   localparam int PERIOD_W    = 10;
   localparam int LEVEL_W     = 7;
   localparam int STEP_W      = 6;
   localparam int LAYER_W     = 5;
   localparam int SEEN_W      = 6;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_POLL_PERIOD  = 3'd0,
      CSR_BLINK_PERIOD = 3'd1,
      CSR_RAMP_PERIOD  = 3'd2,
      CSR_BLINK_HIGH   = 3'd3,
      CSR_BLINK_LOW    = 3'd4,
      CSR_RAMP_MIN     = 3'd5,
      CSR_RAMP_MAX     = 3'd6,
      CSR_RAMP_STEP    = 3'd7
   } lmlpc_csr_index_type;

   // Layer codes
   localparam logic [LAYER_W-1:0] LAYER_FOLLOW     = LAYER_W'(0);
   localparam logic [LAYER_W-1:0] LAYER_BLINK      = LAYER_W'(1);
   localparam logic [LAYER_W-1:0] LAYER_RAMP       = LAYER_W'(2);
   localparam logic [LAYER_W-1:0] LAYER_FAST_BLINK = LAYER_W'(3);
   // Seen layer marker: no layer polled yet
   localparam logic [SEEN_W-1:0]  SEEN_NONE        = SEEN_W'(63);

   // Register reset values
   localparam logic [PERIOD_W-1:0] POLL_PERIOD_RST  = PERIOD_W'(100);
   localparam logic [PERIOD_W-1:0] BLINK_PERIOD_RST = PERIOD_W'(500);
   localparam logic [PERIOD_W-1:0] RAMP_PERIOD_RST  = PERIOD_W'(20);
   localparam logic [LEVEL_W-1:0]  BLINK_HIGH_RST   = LEVEL_W'(100);
   localparam logic [LEVEL_W-1:0]  BLINK_LOW_RST    = LEVEL_W'(10);
   localparam logic [LEVEL_W-1:0]  RAMP_MIN_RST     = LEVEL_W'(10);
   localparam logic [LEVEL_W-1:0]  RAMP_MAX_RST     = LEVEL_W'(100);
   localparam logic [STEP_W-1:0]   RAMP_STEP_RST    = STEP_W'(5);

   typedef struct packed {
      logic [PERIOD_W-1:0] poll_period;
      logic [PERIOD_W-1:0] blink_period;
      logic [PERIOD_W-1:0] ramp_period;
      logic [LEVEL_W-1:0]  blink_high_level;
      logic [LEVEL_W-1:0]  blink_low_level;
      logic [LEVEL_W-1:0]  ramp_min_level;
      logic [LEVEL_W-1:0]  ramp_max_level;
      logic [STEP_W-1:0]   ramp_step;
   } lmlpc_cfg_type;

   typedef struct packed {
      logic                key_pressed;
      logic                underglow_on;
      logic [LEVEL_W-1:0]  underglow_level;
      logic [LAYER_W-1:0]  top_layer;
      logic                is_active;
   } lmlpc_req_type;

   typedef struct packed {
      logic                level_written;
      logic [LEVEL_W-1:0]  led_level;
   } lmlpc_rsp_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] poll_countdown;
      logic [PERIOD_W-1:0] blink_countdown;
      logic                blink_armed;
      logic [PERIOD_W-1:0] ramp_countdown;
      logic                ramp_armed;
      logic [SEEN_W-1:0]   seen_layer;
      logic                seen_active;
      logic                permitted;
      logic                blink_bright;
      logic [LEVEL_W-1:0]  ramp_level;
      logic                ramp_rising;
      logic [LEVEL_W-1:0]  driven_level;
   } lmlpc_state_type;

   // A zero period counts as one tick
   function automatic logic [PERIOD_W-1:0] at_least_one(input logic [PERIOD_W-1:0] v);
      return (v == '0) ? PERIOD_W'(1) : v;
   endfunction

endpackage

@@ rtl/core/layer_mode_led_pattern_controller.sv @@
// Top level of the layer mode LED pattern controller: handshake, staging and result register.
// A request goes from the request register to the result register, which drives rsp_tvalid.
// Throughput: one request per cycle while rsp_tready holds; the request register, the tick update
// in lmlpc_step and the result register form a two-entry pipeline.
// Reset (synchronous, active high): registers return to their defaults, the pattern
// state to its idle values with no layer seen, and both pipeline entries empty.
module layer_mode_led_pattern_controller (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [0] is_active, [5:1] top_layer, [12:6] underglow_level,
   // [13] underglow_on, [14] key_pressed, [15] zero
   input  logic [lmlpc_pkg::REQ_DATA_W-1:0]    req_tdata,
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [6:0] led_level, [7] level_written
   output logic [lmlpc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // configuration write port
   input  logic                                csr_we,
   input  logic [lmlpc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lmlpc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import lmlpc_pkg::*;

   lmlpc_cfg_type cfg;
   lmlpc_rsp_type step_rsp;

   // Request stage: holds one accepted request until the result register can take it
   logic          req_valid_ff;
   logic          req_valid_in;
   lmlpc_req_type req_data_ff;

   // Result stage
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   lmlpc_rsp_type rsp_data_ff;

   logic          advance;
   logic          req_accept;

   // Move the staged request on when the result register is empty or being drained
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_accept) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: the request loads on accept, the result on advance; both hold otherwise
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_data_ff.is_active       <= req_tdata[0];
         req_data_ff.top_layer       <= req_tdata[5:1];
         req_data_ff.underglow_level <= req_tdata[12:6];
         req_data_ff.underglow_on    <= req_tdata[13];
         req_data_ff.key_pressed     <= req_tdata[14];
      end
      if (advance) begin
         rsp_data_ff <= step_rsp;
      end
   end

   lmlpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // One tick of pattern state per request, committed as it enters the result register
   lmlpc_step u_step (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .cfg     (cfg),
      .req     (req_data_ff),
      .rsp     (step_rsp)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff.level_written, rsp_data_ff.led_level};

   // A request is never taken while the staging register is full and stuck
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_valid_ff) |-> advance)
      else $error("request accepted over a stalled staged request");

   // A staged request that advances always shows up as a result
   a_advance_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("advanced request produced no result");

   // A staged request waits only while a result is held back
   a_stall_reason: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !advance) |-> (rsp_valid_ff && !rsp_tready))
      else $error("staged request stalled without back pressure");

endmodule

@@ rtl/core/lmlpc_csr.sv @@
// Configuration register file of the layer mode LED pattern controller.
module lmlpc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [lmlpc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lmlpc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output lmlpc_pkg::lmlpc_cfg_type        cfg
);
   import lmlpc_pkg::*;

   lmlpc_cfg_type cfg_ff;
   lmlpc_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (lmlpc_csr_index_type'(csr_index))
            CSR_POLL_PERIOD:  cfg_in.poll_period      = csr_wdata;
            CSR_BLINK_PERIOD: cfg_in.blink_period     = csr_wdata;
            CSR_RAMP_PERIOD:  cfg_in.ramp_period      = csr_wdata;
            CSR_BLINK_HIGH:   cfg_in.blink_high_level = csr_wdata[LEVEL_W-1:0];
            CSR_BLINK_LOW:    cfg_in.blink_low_level  = csr_wdata[LEVEL_W-1:0];
            CSR_RAMP_MIN:     cfg_in.ramp_min_level   = csr_wdata[LEVEL_W-1:0];
            CSR_RAMP_MAX:     cfg_in.ramp_max_level   = csr_wdata[LEVEL_W-1:0];
            CSR_RAMP_STEP:    cfg_in.ramp_step        = csr_wdata[STEP_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.poll_period      <= POLL_PERIOD_RST;
         cfg_ff.blink_period     <= BLINK_PERIOD_RST;
         cfg_ff.ramp_period      <= RAMP_PERIOD_RST;
         cfg_ff.blink_high_level <= BLINK_HIGH_RST;
         cfg_ff.blink_low_level  <= BLINK_LOW_RST;
         cfg_ff.ramp_min_level   <= RAMP_MIN_RST;
         cfg_ff.ramp_max_level   <= RAMP_MAX_RST;
         cfg_ff.ramp_step        <= RAMP_STEP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/lmlpc_step.sv @@
// Per-tick pattern state and its combinational update: key, timers, then poll.
module lmlpc_step (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step_en,
   input  lmlpc_pkg::lmlpc_cfg_type  cfg,
   input  lmlpc_pkg::lmlpc_req_type  req,
   output lmlpc_pkg::lmlpc_rsp_type  rsp
);
   import lmlpc_pkg::*;

   lmlpc_state_type state_ff;
   lmlpc_state_type state_in;
   logic            wrote;

   always_comb begin
      logic [LEVEL_W:0] ramp_sum;
      ramp_sum = '0;
      state_in = state_ff;
      wrote    = 1'b0;

      if (req.key_pressed) begin
         state_in.permitted = 1'b1;
      end

      // blink timer
      if (state_in.blink_armed) begin
         if (state_in.blink_countdown <= PERIOD_W'(1)) begin
            state_in.blink_countdown = '0;
            if (state_in.seen_layer != {1'b0, LAYER_BLINK} &&
                state_in.seen_layer != {1'b0, LAYER_FAST_BLINK}) begin
               state_in.driven_level = '0;
               wrote                 = 1'b1;
               state_in.blink_armed  = 1'b0;
            end else begin
               state_in.blink_bright = !state_in.blink_bright;
               state_in.driven_level = state_in.blink_bright ? cfg.blink_high_level
                                                             : cfg.blink_low_level;
               wrote                 = 1'b1;
               state_in.blink_countdown =
                  at_least_one((state_in.seen_layer == {1'b0, LAYER_FAST_BLINK})
                               ? (cfg.blink_period >> 1) : cfg.blink_period);
               state_in.blink_armed  = 1'b1;
            end
         end else begin
            state_in.blink_countdown = state_in.blink_countdown - PERIOD_W'(1);
         end
      end

      // ramp timer
      if (state_in.ramp_armed) begin
         if (state_in.ramp_countdown <= PERIOD_W'(1)) begin
            state_in.ramp_countdown = '0;
            if (state_in.seen_layer != {1'b0, LAYER_RAMP}) begin
               state_in.driven_level = '0;
               wrote                 = 1'b1;
               state_in.ramp_armed   = 1'b0;
            end else begin
               state_in.driven_level = state_in.ramp_level;
               wrote                 = 1'b1;
               ramp_sum = {1'b0, state_in.ramp_level} + {2'b00, cfg.ramp_step};
               if (state_in.ramp_rising) begin
                  if (ramp_sum >= {1'b0, cfg.ramp_max_level}) begin
                     state_in.ramp_level  = cfg.ramp_max_level;
                     state_in.ramp_rising = 1'b0;
                  end else begin
                     state_in.ramp_level = ramp_sum[LEVEL_W-1:0];
                  end
               end else if (state_in.ramp_level < {1'b0, cfg.ramp_step}) begin
                  state_in.ramp_level  = cfg.ramp_min_level;
                  state_in.ramp_rising = 1'b1;
               end else begin
                  state_in.ramp_level = state_in.ramp_level - {1'b0, cfg.ramp_step};
               end
               state_in.ramp_countdown = at_least_one(cfg.ramp_period);
               state_in.ramp_armed     = 1'b1;
            end
         end else begin
            state_in.ramp_countdown = state_in.ramp_countdown - PERIOD_W'(1);
         end
      end

      // status poll
      if (state_in.poll_countdown <= PERIOD_W'(1)) begin
         if (!req.is_active) begin
            state_in.permitted = 1'b0;
         end
         if ({1'b0, req.top_layer} != state_in.seen_layer ||
             req.is_active != state_in.seen_active) begin
            state_in.seen_layer   = {1'b0, req.top_layer};
            state_in.seen_active  = req.is_active;
            state_in.blink_armed  = 1'b0;
            state_in.ramp_armed   = 1'b0;
            state_in.blink_bright = 1'b0;
            state_in.ramp_level   = cfg.ramp_min_level;
            state_in.ramp_rising  = 1'b1;
            case (req.top_layer)
               LAYER_FOLLOW: begin
                  // written below
               end
               LAYER_BLINK: begin
                  state_in.blink_bright    = !req.underglow_on;
                  state_in.driven_level    = (req.is_active && state_in.blink_bright)
                                             ? cfg.blink_high_level : cfg.blink_low_level;
                  wrote                    = 1'b1;
                  state_in.blink_countdown = at_least_one(cfg.blink_period >> 1);
                  state_in.blink_armed     = 1'b1;
               end
               LAYER_RAMP: begin
                  state_in.ramp_countdown = at_least_one(cfg.poll_period);
                  state_in.ramp_armed     = 1'b1;
               end
               LAYER_FAST_BLINK: begin
                  state_in.blink_bright    = 1'b0;
                  state_in.driven_level    = cfg.blink_low_level;
                  wrote                    = 1'b1;
                  state_in.blink_countdown = at_least_one(cfg.blink_period >> 1);
                  state_in.blink_armed     = 1'b1;
               end
               default: begin
                  state_in.driven_level = '0;
                  wrote                 = 1'b1;
               end
            endcase
         end
         if (req.top_layer == LAYER_FOLLOW) begin
            state_in.driven_level = (req.underglow_on && req.is_active && state_in.permitted)
                                    ? req.underglow_level : '0;
            wrote                 = 1'b1;
         end
         state_in.poll_countdown = at_least_one(cfg.poll_period);
      end else begin
         state_in.poll_countdown = state_in.poll_countdown - PERIOD_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.poll_countdown  <= POLL_PERIOD_RST;
         state_ff.blink_countdown <= '0;
         state_ff.blink_armed     <= 1'b0;
         state_ff.ramp_countdown  <= '0;
         state_ff.ramp_armed      <= 1'b0;
         state_ff.seen_layer      <= SEEN_NONE;
         state_ff.seen_active     <= 1'b0;
         state_ff.permitted       <= 1'b0;
         state_ff.blink_bright    <= 1'b0;
         state_ff.ramp_level      <= RAMP_MIN_RST;
         state_ff.ramp_rising     <= 1'b1;
         state_ff.driven_level    <= '0;
      end else if (step_en) begin
         state_ff <= state_in;
      end
   end

   assign rsp.led_level     = state_in.driven_level;
   assign rsp.level_written = wrote;

   // An armed timer always holds a count of at least one
   a_blink_armed_count: assert property (@(posedge clock) disable iff (reset)
      state_ff.blink_armed |-> (state_ff.blink_countdown != '0))
      else $error("blink timer armed with zero count");

   a_ramp_armed_count: assert property (@(posedge clock) disable iff (reset)
      state_ff.ramp_armed |-> (state_ff.ramp_countdown != '0))
      else $error("ramp timer armed with zero count");

   a_poll_count: assert property (@(posedge clock) disable iff (reset)
      state_ff.poll_countdown != '0)
      else $error("poll countdown reached zero");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking stream testbench for the layer mode LED pattern controller.
module tb;
   import lmlpc_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_TICKS = 4;      // margin for results to drain through the pipeline
   localparam int PHASE_ITEMS  = 105;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   // [0] is_active, [5:1] top_layer, [12:6] underglow_level,
   // [13] underglow_on, [14] key_pressed, [15] zero
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // [6:0] led_level, [7] level_written
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   layer_mode_led_pattern_controller DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 4 ns clock
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // ------------------------------------------------------------------
   // Pattern predictor: shadow registers and the tick-by-tick state
   // ------------------------------------------------------------------
   lmlpc_cfg_type         cfg_shadow;
   logic [PERIOD_W-1:0]   poll_left;
   logic [PERIOD_W-1:0]   blink_left;
   logic [PERIOD_W-1:0]   ramp_left;
   logic                  blink_running;
   logic                  ramp_running;
   logic [SEEN_W-1:0]     layer_seen;
   logic                  active_seen;
   logic                  key_permit;
   logic                  blink_phase_hi;
   logic [LEVEL_W-1:0]    ramp_lvl;
   logic                  ramp_going_up;
   logic [LEVEL_W-1:0]    led_now;
   logic                  led_touched;

   // LED levels still owed by the block, oldest first
   lmlpc_rsp_type         led_expected_q[$];

   int                    mismatch_count;
   int                    cycle_count;
   int                    send_idle_pct;
   int                    recv_idle_pct;

   function automatic logic [PERIOD_W-1:0] nonzero_ticks(input logic [PERIOD_W-1:0] n);
      return (n == '0) ? PERIOD_W'(1) : n;
   endfunction

   // Bring the predictor to its post-reset condition
   function automatic void clear_pattern_state();
      cfg_shadow.poll_period      = POLL_PERIOD_RST;
      cfg_shadow.blink_period     = BLINK_PERIOD_RST;
      cfg_shadow.ramp_period      = RAMP_PERIOD_RST;
      cfg_shadow.blink_high_level = BLINK_HIGH_RST;
      cfg_shadow.blink_low_level  = BLINK_LOW_RST;
      cfg_shadow.ramp_min_level   = RAMP_MIN_RST;
      cfg_shadow.ramp_max_level   = RAMP_MAX_RST;
      cfg_shadow.ramp_step        = RAMP_STEP_RST;
      poll_left      = POLL_PERIOD_RST;
      blink_left     = '0;
      ramp_left      = '0;
      blink_running  = 1'b0;
      ramp_running   = 1'b0;
      layer_seen     = SEEN_NONE;
      active_seen    = 1'b0;
      key_permit     = 1'b0;
      blink_phase_hi = 1'b0;
      ramp_lvl       = RAMP_MIN_RST;
      ramp_going_up  = 1'b1;
      led_now        = '0;
      led_touched    = 1'b0;
   endfunction

   function automatic void led_set(input logic [LEVEL_W-1:0] lvl);
      led_now     = lvl;
      led_touched = 1'b1;
   endfunction

   function automatic void blink_restart(input logic [PERIOD_W-1:0] n);
      blink_left    = nonzero_ticks(n);
      blink_running = 1'b1;
   endfunction

   function automatic void blink_expired();
      if (layer_seen != LAYER_BLINK && layer_seen != LAYER_FAST_BLINK) begin
         // timer outlived its layer: go dark and stop
         led_set('0);
         blink_running = 1'b0;
      end else begin
         blink_phase_hi = !blink_phase_hi;
         led_set(blink_phase_hi ? cfg_shadow.blink_high_level : cfg_shadow.blink_low_level);
         blink_restart((layer_seen == LAYER_FAST_BLINK) ? (cfg_shadow.blink_period >> 1)
                                                         : cfg_shadow.blink_period);
      end
   endfunction

   function automatic void ramp_expired();
      int unsigned sum;
      if (layer_seen != LAYER_RAMP) begin
         led_set('0);
         ramp_running = 1'b0;
      end else begin
         // write the current level, then step toward the next one
         led_set(ramp_lvl);
         if (ramp_going_up) begin
            sum = int'(ramp_lvl) + int'(cfg_shadow.ramp_step);
            if (sum >= cfg_shadow.ramp_max_level) begin
               ramp_lvl      = cfg_shadow.ramp_max_level;
               ramp_going_up = 1'b0;
            end else begin
               ramp_lvl = LEVEL_W'(sum);
            end
         end else if (ramp_lvl < cfg_shadow.ramp_step) begin
            // the ramp has already touched bottom; restart at the minimum
            ramp_lvl      = cfg_shadow.ramp_min_level;
            ramp_going_up = 1'b1;
         end else begin
            ramp_lvl = ramp_lvl - LEVEL_W'(cfg_shadow.ramp_step);
         end
         ramp_left    = nonzero_ticks(cfg_shadow.ramp_period);
         ramp_running = 1'b1;
      end
   endfunction

   function automatic void status_poll(input lmlpc_req_type r);
      if (!r.is_active)
         key_permit = 1'b0;
      if ({1'b0, r.top_layer} != layer_seen || r.is_active != active_seen) begin
         // new layer or activity: drop both timers and restart the pattern
         layer_seen     = {1'b0, r.top_layer};
         active_seen    = r.is_active;
         blink_running  = 1'b0;
         ramp_running   = 1'b0;
         blink_phase_hi = 1'b0;
         ramp_lvl       = cfg_shadow.ramp_min_level;
         ramp_going_up  = 1'b1;
         case (r.top_layer)
            LAYER_FOLLOW: ;
            LAYER_BLINK: begin
               blink_phase_hi = !r.underglow_on;
               led_set((r.is_active && blink_phase_hi) ? cfg_shadow.blink_high_level
                                                       : cfg_shadow.blink_low_level);
               blink_restart(cfg_shadow.blink_period >> 1);
            end
            LAYER_RAMP: begin
               ramp_left    = nonzero_ticks(cfg_shadow.poll_period);
               ramp_running = 1'b1;
            end
            LAYER_FAST_BLINK: begin
               blink_phase_hi = 1'b0;
               led_set(cfg_shadow.blink_low_level);
               blink_restart(cfg_shadow.blink_period >> 1);
            end
            default: led_set('0);
         endcase
      end
      if (r.top_layer == LAYER_FOLLOW)
         led_set((r.underglow_on && r.is_active && key_permit) ? r.underglow_level : '0);
      poll_left = nonzero_ticks(cfg_shadow.poll_period);
   endfunction

   // One tick: key press, then the timers, then the poll
   function automatic lmlpc_rsp_type predict_led_tick(input lmlpc_req_type r);
      lmlpc_rsp_type o;
      led_touched = 1'b0;
      if (r.key_pressed)
         key_permit = 1'b1;
      if (blink_running) begin
         if (blink_left <= 1) begin
            blink_left = '0;
            blink_expired();
         end else begin
            blink_left--;
         end
      end
      if (ramp_running) begin
         if (ramp_left <= 1) begin
            ramp_left = '0;
            ramp_expired();
         end else begin
            ramp_left--;
         end
      end
      if (poll_left <= 1)
         status_poll(r);
      else
         poll_left--;
      o.led_level     = led_now;
      o.level_written = led_touched;
      return o;
   endfunction

   function automatic void shadow_register_write(input lmlpc_csr_index_type idx,
                                                 input logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_POLL_PERIOD:  cfg_shadow.poll_period      = val;
         CSR_BLINK_PERIOD: cfg_shadow.blink_period     = val;
         CSR_RAMP_PERIOD:  cfg_shadow.ramp_period      = val;
         CSR_BLINK_HIGH:   cfg_shadow.blink_high_level = val[LEVEL_W-1:0];
         CSR_BLINK_LOW:    cfg_shadow.blink_low_level  = val[LEVEL_W-1:0];
         CSR_RAMP_MIN:     cfg_shadow.ramp_min_level   = val[LEVEL_W-1:0];
         CSR_RAMP_MAX:     cfg_shadow.ramp_max_level   = val[LEVEL_W-1:0];
         CSR_RAMP_STEP:    cfg_shadow.ramp_step        = val[STEP_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic lmlpc_req_type make_request(input logic active,
                                                  input logic [LAYER_W-1:0] layer,
                                                  input logic [LEVEL_W-1:0] ug_level,
                                                  input logic ug_on, input logic key);
      lmlpc_req_type r;
      r.is_active       = active;
      r.top_layer       = layer;
      r.underglow_level = ug_level;
      r.underglow_on    = ug_on;
      r.key_pressed     = key;
      return r;
   endfunction

   function automatic void flag_mismatch(input string what, input lmlpc_rsp_type want,
                                         input lmlpc_rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s: expected level %0d written %0b, got level %0d written %0b",
                  $time, what, want.led_level, want.level_written,
                  got.led_level, got.level_written);
   endfunction

   // ------------------------------------------------------------------
   // Drivers: everything changes at the falling edge
   // ------------------------------------------------------------------

   // Offer one request, with random idle ticks ahead of it; predict on acceptance
   task automatic send_request(input lmlpc_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata  = REQ_DATA_W'(r);
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      led_expected_q.push_back(predict_led_tick(r));
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // Hold off register writes until every pending result has drained
   task automatic wait_for_idle();
      while (led_expected_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   task automatic load_settings(input logic [CSR_DATA_W-1:0] poll, blink, ramp,
                                input logic [CSR_DATA_W-1:0] hi, lo, rmin, rmax, step);
      logic [CSR_DATA_W-1:0] vals [8];
      lmlpc_csr_index_type   idx;
      vals = '{poll, blink, ramp, hi, lo, rmin, rmax, step};
      wait_for_idle();
      for (int i = 0; i < 8; i++) begin
         idx       = lmlpc_csr_index_type'(i);
         csr_we    = 1'b1;
         csr_index = idx;
         csr_wdata = vals[i];
         shadow_register_write(idx, vals[i]);
         @(negedge clock);
      end
      csr_we = 1'b0;
   endtask

   // Randomly stall the result side
   always @(negedge clock)
      rsp_tready = ($urandom_range(99) >= recv_idle_pct);

   // ------------------------------------------------------------------
   // Result checker: compare every accepted result with the oldest prediction
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      lmlpc_rsp_type got;
      lmlpc_rsp_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got = rsp_tdata;
         if (led_expected_q.size() == 0) begin
            flag_mismatch("result with no request pending", '0, got);
         end else begin
            want = led_expected_q.pop_front();
            if (got.led_level !== want.led_level)
               flag_mismatch("led_level", want, got);
            else if (got.level_written !== want.level_written)
               flag_mismatch("level_written", want, got);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Layer 0: underglow passes through only after a key press while active
   task automatic test_underglow_follow();
      // zero poll and ramp periods and a blink half period of zero all act as one tick;
      // ramp minimum above its maximum with a wide step
      load_settings(0, 1, 0, 100, 0, 60, 20, 50);
      send_request(make_request(1, LAYER_FOLLOW, 127, 1, 0));
      send_request(make_request(1, LAYER_FOLLOW, 127, 1, 1));
      send_request(make_request(1, LAYER_FOLLOW, 0, 1, 0));
      send_request(make_request(1, LAYER_FOLLOW, 85, 0, 0));
      // key and idle in one tick: the poll clears the permission again
      send_request(make_request(0, LAYER_FOLLOW, 42, 1, 1));
      send_request(make_request(1, LAYER_FOLLOW, 100, 1, 0));
      send_request(make_request(1, LAYER_FOLLOW, 100, 1, 1));
   endtask

   // Layers 1 and 3: toggle between bright and dim, restart on an activity change
   task automatic test_blink_layers();
      repeat (4) send_request(make_request(1, LAYER_BLINK, 7, 0, 0));
      repeat (2) send_request(make_request(0, LAYER_BLINK, 120, 1, 1));
      repeat (4) send_request(make_request(1, LAYER_FAST_BLINK, 64, 1, 0));
   endtask

   // Layer 2 ramps; layers above 3 are dark
   task automatic test_ramp_and_dark_layers();
      repeat (5) send_request(make_request(1, LAYER_RAMP, 33, 1, 1));
      send_request(make_request(1, 5'd31, 127, 1, 1));
      send_request(make_request(0, 5'd4, 0, 0, 0));
      send_request(make_request(1, 5'd16, 99, 1, 0));
   endtask

   // Mostly runs of one layer with random content, plus some pure noise
   task automatic test_random_traffic(input int phase, input int n_items);
      int                           sent;
      int                           run_len;
      logic [LAYER_W-1:0]           layer;
      logic                         act;
      logic                         ug_on;
      logic [31:0]                  noise;
      lmlpc_req_type                r;
      case (phase)
         1: load_settings(1, 1000, 1000, 100, 100, 100, 100, 50);
         3: load_settings(1000, 2, 1, 0, 0, 0, 0, 1);
         default: load_settings(CSR_DATA_W'(($urandom_range(9) == 0)
                                            ? $urandom_range(1000, 100)
                                            : $urandom_range(6, 0)),
                                CSR_DATA_W'($urandom_range(24, 0)),
                                CSR_DATA_W'($urandom_range(5, 0)),
                                CSR_DATA_W'($urandom_range(100, 0)),
                                CSR_DATA_W'($urandom_range(100, 0)),
                                CSR_DATA_W'($urandom_range(100, 0)),
                                CSR_DATA_W'($urandom_range(100, 0)),
                                CSR_DATA_W'($urandom_range(25, 1)));
      endcase
      sent = 0;
      while (sent < n_items) begin
         layer   = ($urandom_range(99) < 75) ? LAYER_W'($urandom_range(3, 0))
                                             : LAYER_W'($urandom_range(31, 0));
         run_len = $urandom_range(40, 4);
         if (run_len > n_items - sent)
            run_len = n_items - sent;
         act     = ($urandom_range(9) != 0);
         ug_on   = 1'($urandom_range(1, 0));
         repeat (run_len) begin
            if ($urandom_range(99) < 15) begin
               noise = $urandom;
               r     = noise[$bits(lmlpc_req_type)-1:0];
            end else begin
               if ($urandom_range(19) == 0)
                  act = !act;
               if ($urandom_range(9) == 0)
                  ug_on = !ug_on;
               r = make_request(act, layer, LEVEL_W'($urandom_range(127, 0)), ug_on,
                                $urandom_range(99) < 12);
            end
            send_request(r);
            sent++;
         end
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      rsp_tready     = 1'b0;
      csr_we         = 1'b0;
      csr_index      = CSR_POLL_PERIOD;
      csr_wdata      = '0;
      mismatch_count = 0;
      cycle_count    = 0;
      send_idle_pct  = 20;
      recv_idle_pct  = 87;
      clear_pattern_state();

      // single reset pulse at the start of the run
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_underglow_follow();
      test_blink_layers();
      test_ramp_and_dark_layers();

      // receiver choked, then sender sparse, then full speed
      for (int phase = 0; phase < 6; phase++) begin
         case (phase / 2)
            0: begin
               send_idle_pct = 20;
               recv_idle_pct = 87;
            end
            1: begin
               send_idle_pct = 87;
               recv_idle_pct = 20;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         test_random_traffic(phase, PHASE_ITEMS);
      end

      // drain, then allow the pipeline to settle
      while (led_expected_q.size() != 0)
         @(posedge clock);
      repeat (2 * SETTLE_TICKS) @(posedge clock);
      if (led_expected_q.size() != 0)
         mismatch_count++;

      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

@@ layer_mode_led_pattern_controller.f @@
rtl/core/lmlpc_pkg.sv
rtl/core/lmlpc_csr.sv
rtl/core/lmlpc_step.sv
rtl/core/layer_mode_led_pattern_controller.sv
tb/sv/tb.sv
